// ===== sv/cetat_pkg.sv =====
// Shared types, constants and the font remap function for the color escape translator.
package cetat_pkg;

	localparam int MaxRun = 7;

	localparam logic [7:0] EscByte  = 8'h1B;
	localparam logic [7:0] LbrByte  = 8'h5B;
	localparam logic [7:0] MByte    = 8'h6D;
	localparam logic [7:0] SemiByte = 8'h3B;
	localparam logic [7:0] NlByte   = 8'h0A;
	localparam logic [7:0] ZeroChr  = 8'h30;
	localparam logic [7:0] NineChr  = 8'h39;

	localparam logic [1:0] RegColorMode = 2'd0;
	localparam logic [1:0] RegFontRemap = 2'd1;
	localparam logic [1:0] RegEscChar   = 2'd2;

	localparam logic [1:0] ModeStrip = 2'd0;
	localparam logic [1:0] ModeXlate = 2'd1;
	localparam logic [1:0] ModePass  = 2'd2;

	localparam logic [3:0] ColDefault = 4'd0;
	localparam logic [3:0] ColBright  = 4'd8;

	typedef struct packed {
		logic [1:0] color_mode;
		logic       font_remap_enable;
		logic [7:0] escape_char;
	} cfg_t;

	typedef struct packed {
		logic       esc_pending;
		logic [3:0] active_color;
	} line_st_t;

	typedef struct packed {
		logic [MaxRun-1:0][7:0] bytes;
		logic [2:0]             count;
		logic                   eol;
	} run_t;

	localparam logic [7:0] LowFirst [16] = '{
		8'h00, 8'h23, 8'h23, 8'h23, 8'h23, 8'h2E, 8'h23, 8'h23,
		8'h23, 8'h09, 8'h0A, 8'h23, 8'h20, 8'h0D, 8'h2E, 8'h2E
	};
	localparam logic [7:0] LowSecond [16] = '{
		8'h3C, 8'h3D, 8'h3E, 8'h23, 8'h23, 8'h2E, 8'h23, 8'h23,
		8'h23, 8'h23, 8'h20, 8'h23, 8'h20, 8'h3E, 8'h2E, 8'h2E
	};
	localparam logic [7:0] LowShared [16] = '{
		8'h5B, 8'h5D, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35,
		8'h36, 8'h37, 8'h38, 8'h39, 8'h2E, 8'h3C, 8'h3D, 8'h3E
	};

	function automatic logic [7:0] font_remap(input logic [7:0] b);
		logic [6:0] lo;
		logic [7:0] r;
		lo = b[6:0];
		if (lo == 7'd127) begin
			r = 8'h3C;
		end else if (lo >= 7'd32) begin
			r = {1'b0, lo};
		end else if (lo >= 7'd16) begin
			r = LowShared[lo[3:0]];
		end else if (b[7]) begin
			r = LowSecond[lo[3:0]];
		end else begin
			r = LowFirst[lo[3:0]];
		end
		return r;
	endfunction

endpackage

// ===== sv/cetat_xlate.sv =====
// Translation logic: one request plus line state in, byte run and next line state out.
module cetat_xlate (
	input  logic                 opcode,
	input  logic [7:0]           char_byte,
	input  cetat_pkg::cfg_t      cfg,
	input  cetat_pkg::line_st_t  st,
	output cetat_pkg::run_t      run,
	output cetat_pkg::line_st_t  st_next
);

	logic [7:0] b;
	logic       translate;
	logic       digit;
	logic [3:0] dval;
	logic [3:0] col;
	logic [7:0] tail;

	assign b         = cfg.font_remap_enable ? cetat_pkg::font_remap(char_byte) : char_byte;
	assign translate = (cfg.color_mode == cetat_pkg::ModeXlate);
	assign digit     = (b >= cetat_pkg::ZeroChr) && (b <= cetat_pkg::NineChr);
	assign dval      = b[3:0];

	always_comb begin
		if (dval == 4'd0 || dval == 4'd7) begin
			col = cetat_pkg::ColDefault;
		end else if (dval >= 4'd8) begin
			col = cetat_pkg::ColBright;
		end else begin
			col = dval;
		end
		if (col <= 4'd4) begin
			tail = cetat_pkg::ZeroChr + {4'd0, col};
		end else if (col == 4'd5) begin
			tail = 8'h36;
		end else begin
			tail = 8'h35;
		end
	end

	always_comb begin
		logic [2:0] n;
		logic       plain;
		n       = 3'd0;
		plain   = 1'b0;
		run     = '0;
		st_next = st;
		run.eol = opcode;
		if (opcode) begin
			if (st.esc_pending) begin
				run.bytes[n] = cfg.escape_char; n = n + 3'd1;
			end
			if (st.active_color != cetat_pkg::ColDefault) begin
				run.bytes[n] = cetat_pkg::EscByte; n = n + 3'd1;
				run.bytes[n] = cetat_pkg::LbrByte; n = n + 3'd1;
				run.bytes[n] = cetat_pkg::MByte;   n = n + 3'd1;
			end
			run.bytes[n] = 8'h00; n = n + 3'd1;
			st_next = '0;
		end else if (b != 8'h00) begin
			if (cfg.color_mode == cetat_pkg::ModePass) begin
				if (st.esc_pending) begin
					run.bytes[n] = cfg.escape_char; n = n + 3'd1;
				end
				st_next.esc_pending = 1'b0;
				run.bytes[n] = b; n = n + 3'd1;
			end else if (st.esc_pending) begin
				st_next.esc_pending = 1'b0;
				if (b == cfg.escape_char) begin
					run.bytes[n] = cfg.escape_char; n = n + 3'd1;
				end else if (digit) begin
					if (translate && col != st.active_color) begin
						st_next.active_color = col;
						run.bytes[n] = cetat_pkg::EscByte; n = n + 3'd1;
						run.bytes[n] = cetat_pkg::LbrByte; n = n + 3'd1;
						if (col == cetat_pkg::ColBright) begin
							run.bytes[n] = cetat_pkg::ZeroChr; n = n + 3'd1;
							run.bytes[n] = cetat_pkg::SemiByte; n = n + 3'd1;
							run.bytes[n] = 8'h31; n = n + 3'd1;
						end else if (col != cetat_pkg::ColDefault) begin
							run.bytes[n] = 8'h31; n = n + 3'd1;
							run.bytes[n] = cetat_pkg::SemiByte; n = n + 3'd1;
							run.bytes[n] = 8'h33; n = n + 3'd1;
							run.bytes[n] = tail; n = n + 3'd1;
						end
						run.bytes[n] = cetat_pkg::MByte; n = n + 3'd1;
					end
				end else begin
					run.bytes[n] = cfg.escape_char; n = n + 3'd1;
					plain = 1'b1;
				end
			end else begin
				plain = 1'b1;
			end
			if (plain) begin
				if (b == cfg.escape_char) begin
					st_next.esc_pending = 1'b1;
				end else begin
					if (translate && b == cetat_pkg::NlByte &&
					    st.active_color != cetat_pkg::ColDefault) begin
						run.bytes[n] = cetat_pkg::EscByte; n = n + 3'd1;
						run.bytes[n] = cetat_pkg::LbrByte; n = n + 3'd1;
						run.bytes[n] = cetat_pkg::MByte;   n = n + 3'd1;
						st_next.active_color = cetat_pkg::ColDefault;
					end
					run.bytes[n] = b; n = n + 3'd1;
				end
			end
		end
		run.count = n;
	end

endmodule

// ===== sv/cetat_emit.sv =====
// Output run buffer: holds one byte run and shifts it out one byte per accepted result.
module cetat_emit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  cetat_pkg::run_t  run,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [7:0]       out_byte,
	output logic             last_of_run,
	output logic             line_done,
	output logic             free_next
);

	logic [cetat_pkg::MaxRun-1:0][7:0] buf_q;
	logic [2:0]                        rem_q;
	logic                              eol_q;

	assign out_valid   = (rem_q != 3'd0);
	assign out_byte    = buf_q[0];
	assign last_of_run = (rem_q == 3'd1);
	assign line_done   = eol_q && (rem_q == 3'd1);
	assign free_next   = (rem_q == 3'd0) || ((rem_q == 3'd1) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
		end else if (load) begin
			rem_q <= run.count;
		end else if (out_valid && out_ready) begin
			rem_q <= rem_q - 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= run.bytes;
			eol_q <= run.eol;
		end else if (out_valid && out_ready) begin
			buf_q <= buf_q >> 8;
		end
	end

endmodule

// ===== sv/color_escape_to_ansi_translator.sv =====
// Top level of the color escape to ANSI translator.
//
// Input channel (in_valid/in_ready, opcode, char_byte): one request per line
// character, then one end-of-line request. Output channel (out_valid/out_ready,
// out_byte, last_of_run, line_done): the bytes each request produces, with
// last_of_run on the final byte of a run and line_done on the 0 terminator.
// Configuration (cfg_wr_en, cfg_index, cfg_data) writes color_mode,
// font_remap_enable and escape_char; write only while the block is idle.
// Path: a request is held in the input register, then its run is loaded into
// the output buffer, which presents the first byte; a busy buffer delays the load.
// Throughput: one request per cycle while each gives at most one byte and the
// receiver is ready. A run of up to 7 bytes holds the output buffer until all
// of them have left the single byte-wide output port. Empty requests still load it.
// When the receiver stalls, the output buffer holds and the input register
// fills, then in_ready drops. Reset clears both line state and all valids and
// sets the registers to translate mode, remap on, escape char 0x5E.
module color_escape_to_ansi_translator (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       opcode,
	input  logic [7:0] char_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       last_of_run,
	output logic       line_done,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data
);

	cetat_pkg::cfg_t     cfg_q;
	cetat_pkg::line_st_t st_q;
	cetat_pkg::line_st_t st_next;
	cetat_pkg::run_t     run;

	logic       vld_s1;
	logic       opcode_s1;
	logic [7:0] char_s1;
	logic       free_next;
	logic       load;

	assign load     = vld_s1 && free_next;
	assign in_ready = !vld_s1 || free_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.color_mode        <= cetat_pkg::ModeXlate;
			cfg_q.font_remap_enable <= 1'b1;
			cfg_q.escape_char       <= 8'd94;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				cetat_pkg::RegColorMode: cfg_q.color_mode        <= cfg_data[1:0];
				cetat_pkg::RegFontRemap: cfg_q.font_remap_enable <= cfg_data[0];
				cetat_pkg::RegEscChar:   cfg_q.escape_char       <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			st_q   <= '0;
		end else begin
			if (in_ready) begin
				vld_s1 <= in_valid;
			end
			if (load) begin
				st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			opcode_s1 <= opcode;
			char_s1   <= char_byte;
		end
	end

	cetat_xlate u_xlate (
		.opcode    (opcode_s1),
		.char_byte (char_s1),
		.cfg       (cfg_q),
		.st        (st_q),
		.run       (run),
		.st_next   (st_next)
	);

	cetat_emit u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (load),
		.run         (run),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_byte    (out_byte),
		.last_of_run (last_of_run),
		.line_done   (line_done),
		.free_next   (free_next)
	);

	a_done_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_done |-> out_byte == 8'h00 && last_of_run)
		else $error("terminator byte not zero or not last");

	a_eol_clears: assert property (@(posedge clk) disable iff (!arst_n)
		load && opcode_s1 |=> st_q == '0)
		else $error("line state not cleared at end of line");

	a_color_legal: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.active_color <= cetat_pkg::ColBright && st_q.active_color != 4'd7)
		else $error("illegal active color");

	a_load_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		load && out_valid |-> last_of_run && out_ready)
		else $error("run loaded over unsent bytes");

endmodule

// ===== sim/color_escape_to_ansi_translator_test.sv =====
// Self-checking testbench for the color escape to ANSI translator, with a scoreboard predictor.
`timescale 1ns / 1ps

module color_escape_to_ansi_translator_test;

	localparam int CycleLimit = 400000;
	localparam int DrainCycles = 10;
	localparam int Phases = 8;
	localparam int PhaseItems = 25;

	localparam logic OpChar = 1'b0;
	localparam logic OpEol  = 1'b1;
	localparam logic [1:0] ModeStripAlt = 2'd3;

	typedef struct {
		bit [7:0] b;
		bit       last;
		bit       done;
	} out_beat_t;

	class ansi_line_board;
		bit [1:0] mode;
		bit       remap_on;
		bit [7:0] esc_chr;
		bit       esc_wait;
		bit [3:0] color;
		bit [7:0] tab_first[16];
		bit [7:0] tab_second[16];
		bit [7:0] tab_shared[16];
		bit [7:0] run[$];
		out_beat_t beats[$];
		int errors;

		function new();
			mode = cetat_pkg::ModeXlate;
			remap_on = 1'b1;
			esc_chr = 8'd94;
			esc_wait = 1'b0;
			color = cetat_pkg::ColDefault;
			errors = 0;
			tab_first = '{8'h00, "#", "#", "#", "#", ".", "#", "#",
				"#", 8'h09, 8'h0A, "#", " ", 8'h0D, ".", "."};
			tab_second = '{"<", "=", ">", "#", "#", ".", "#", "#",
				"#", "#", " ", "#", " ", ">", ".", "."};
			tab_shared = '{"[", "]", "0", "1", "2", "3", "4", "5",
				"6", "7", "8", "9", ".", "<", "=", ">"};
		endfunction

		function void write_reg(bit [1:0] idx, bit [7:0] data);
			case (idx)
				cetat_pkg::RegColorMode: mode = data[1:0];
				cetat_pkg::RegFontRemap: remap_on = data[0];
				cetat_pkg::RegEscChar:   esc_chr = data;
				default: ;
			endcase
		endfunction

		function bit [7:0] font_to_ascii(bit [7:0] b);
			bit [6:0] lo;
			lo = b[6:0];
			if (lo == 7'd127)
				return "<";
			if (lo >= 7'd32)
				return {1'b0, lo};
			if (lo >= 7'd16)
				return tab_shared[lo - 7'd16];
			return b[7] ? tab_second[lo[3:0]] : tab_first[lo[3:0]];
		endfunction

		function void add_reset_seq();
			run.push_back(cetat_pkg::EscByte);
			run.push_back(cetat_pkg::LbrByte);
			run.push_back(cetat_pkg::MByte);
		endfunction

		function void pick_color(bit [7:0] d);
			bit [3:0] col;
			bit [7:0] tail;
			if (d == "0" || d == "7")
				col = cetat_pkg::ColDefault;
			else if (d == "8" || d == "9")
				col = cetat_pkg::ColBright;
			else
				col = 4'(d - cetat_pkg::ZeroChr);
			if (col == color)
				return;
			color = col;
			if (col == cetat_pkg::ColDefault) begin
				add_reset_seq();
				return;
			end
			run.push_back(cetat_pkg::EscByte);
			run.push_back(cetat_pkg::LbrByte);
			if (col == cetat_pkg::ColBright) begin
				run.push_back("0");
				run.push_back(cetat_pkg::SemiByte);
				run.push_back("1");
				run.push_back(cetat_pkg::MByte);
				return;
			end
			if (col <= 4'd4)
				tail = cetat_pkg::ZeroChr + 8'(col);
			else if (col == 4'd5)
				tail = "6";
			else
				tail = "5";
			run.push_back("1");
			run.push_back(cetat_pkg::SemiByte);
			run.push_back("3");
			run.push_back(tail);
			run.push_back(cetat_pkg::MByte);
		endfunction

		function void plain_char(bit [7:0] b, bit xl);
			if (b == esc_chr) begin
				esc_wait = 1'b1;
				return;
			end
			if (xl && b == cetat_pkg::NlByte && color != cetat_pkg::ColDefault) begin
				add_reset_seq();
				color = cetat_pkg::ColDefault;
			end
			run.push_back(b);
		endfunction

		function void build_run(bit op, bit [7:0] raw);
			bit [7:0] b;
			bit xl;
			b = raw;
			xl = (mode == cetat_pkg::ModeXlate);
			if (op == OpEol) begin
				if (esc_wait)
					run.push_back(esc_chr);
				if (color != cetat_pkg::ColDefault)
					add_reset_seq();
				run.push_back(8'h00);
				esc_wait = 1'b0;
				color = cetat_pkg::ColDefault;
				return;
			end
			if (remap_on)
				b = font_to_ascii(b);
			if (b == 8'h00)
				return;
			if (mode == cetat_pkg::ModePass) begin
				if (esc_wait)
					run.push_back(esc_chr);
				esc_wait = 1'b0;
				run.push_back(b);
			end else if (esc_wait) begin
				esc_wait = 1'b0;
				if (b == esc_chr) begin
					run.push_back(esc_chr);
				end else if (b >= cetat_pkg::ZeroChr && b <= cetat_pkg::NineChr) begin
					if (xl)
						pick_color(b);
				end else begin
					run.push_back(esc_chr);
					plain_char(b, xl);
				end
			end else begin
				plain_char(b, xl);
			end
		endfunction

		function void note_request(bit op, bit [7:0] raw);
			bit fin;
			run.delete();
			build_run(op, raw);
			foreach (run[k]) begin
				fin = (k == run.size() - 1);
				beats.push_back(out_beat_t'{run[k], fin, fin && (op == OpEol)});
			end
		endfunction

		function void check_result(bit [7:0] b, bit l, bit d);
			out_beat_t want;
			if (beats.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected output: byte %h last %b done %b", b, l, d);
				return;
			end
			want = beats.pop_front();
			if (want.b != b || want.last != l || want.done != d) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected byte %h last %b done %b, got byte %h last %b done %b",
						want.b, want.last, want.done, b, l, d);
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       opcode = 1'b0;
	logic [7:0] char_byte = 8'h00;
	logic       out_ready = 1'b0;
	logic       cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = 2'd0;
	logic [7:0] cfg_data = 8'h00;
	logic       in_ready;
	logic       out_valid;
	logic [7:0] out_byte;
	logic       last_of_run;
	logic       line_done;

	ansi_line_board board;
	int cycles = 0;
	int stall_left = 0;
	int calm_left = 0;
	int roll;

	color_escape_to_ansi_translator uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.char_byte(char_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_byte(out_byte),
		.last_of_run(last_of_run),
		.line_done(line_done),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// output side: random stalls, occasional long ones, occasional calm stretches
	always @(posedge clk) begin
		if (out_valid && out_ready)
			board.check_result(out_byte, last_of_run, line_done);
		if (calm_left > 0) begin
			calm_left--;
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 2) begin
				calm_left = $urandom_range(50, 200);
				out_ready <= 1'b1;
			end else if (roll < 5) begin
				stall_left = $urandom_range(10, 40);
				out_ready <= 1'b0;
			end else if (roll < 25) begin
				stall_left = $urandom_range(0, 2);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// called at a rising edge; returns at the edge where the request is taken, or after the idle gap that follows it
	task automatic send_request(bit op, bit [7:0] b, bit burst);
		int gap;
		in_valid <= 1'b1;
		opcode <= op;
		char_byte <= b;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_request(op, b);
		gap = burst ? 0 : gap_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.beats.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic configure(bit [1:0] m, bit r, bit [7:0] e);
		bit [7:0] vals[3];
		bit [1:0] regs[3];
		vals = '{{6'b0, m}, {7'b0, r}, e};
		regs = '{cetat_pkg::RegColorMode, cetat_pkg::RegFontRemap, cetat_pkg::RegEscChar};
		cfg_wr_en <= 1'b1;
		for (int i = 0; i < 3; i++) begin
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			@(posedge clk);
			board.write_reg(regs[i], vals[i]);
		end
		cfg_wr_en <= 1'b0;
	endtask

	task automatic run_phase(int count, bit burst);
		int sent;
		int kind;
		bit [7:0] esc;
		sent = 0;
		while (sent < count) begin
			kind = $urandom_range(0, 99);
			esc = (board.esc_chr == 8'h00) ? 8'd94 : board.esc_chr;
			if (kind < 28) begin
				send_request(OpChar, 8'($urandom_range(1, 255)), burst);
				sent += 1;
			end else if (kind < 46) begin
				send_request(OpChar, 8'($urandom_range(32, 126)), burst);
				sent += 1;
			end else if (kind < 68) begin
				send_request(OpChar, esc, burst);
				send_request(OpChar, cetat_pkg::ZeroChr + 8'($urandom_range(0, 9)), burst);
				sent += 2;
			end else if (kind < 74) begin
				send_request(OpChar, esc, burst);
				send_request(OpChar, esc, burst);
				sent += 2;
			end else if (kind < 79) begin
				send_request(OpChar, esc, burst);
				send_request(OpChar, 8'($urandom_range(1, 255)), burst);
				sent += 2;
			end else if (kind < 85) begin
				send_request(OpChar, cetat_pkg::NlByte, burst);
				sent += 1;
			end else if (kind < 92) begin
				send_request(OpEol, 8'($urandom_range(0, 255)), burst);
				sent += 1;
			end else if (kind < 96) begin
				send_request(OpChar, esc, burst);
				send_request(OpEol, 8'($urandom_range(0, 255)), burst);
				sent += 2;
			end else begin
				send_request(OpChar, 8'($urandom_range(1, 31)), burst);
				sent += 1;
			end
		end
	endtask

	initial begin
		bit [8:0] script[$];
		board = new();
		script = '{
			{OpChar, "A"},
			{OpChar, "^"}, {OpChar, "1"}, {OpChar, "^"}, {OpChar, "1"},
			{OpChar, "^"}, {OpChar, "5"}, {OpChar, "^"}, {OpChar, "8"},
			{OpChar, "^"}, {OpChar, "9"}, {OpChar, "^"}, {OpChar, "7"},
			{OpChar, "^"}, {OpChar, "2"}, {OpChar, cetat_pkg::NlByte},
			{OpChar, "^"}, {OpChar, "^"}, {OpChar, "^"}, {OpChar, "x"},
			{OpChar, 8'h00}, {OpChar, 8'hFF}, {OpChar, 8'h90},
			{OpChar, "^"}, {OpChar, "3"}, {OpChar, "^"}, {OpEol, 8'hA5},
			{OpChar, "^"}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (script[i])
			send_request(script[i][8], script[i][7:0], 1'b0);
		drain();
		for (int p = 0; p < Phases; p++) begin
			case (p)
				0: configure(cetat_pkg::ModePass, 1'b1, 8'd94);
				1: configure(cetat_pkg::ModeStrip, 1'b0, 8'h00);
				2: configure(ModeStripAlt, 1'b0, "5");
				3: configure(cetat_pkg::ModeXlate, 1'b0, cetat_pkg::NlByte);
				4: configure(cetat_pkg::ModePass, 1'b1, 8'hFF);
				5: configure(cetat_pkg::ModeXlate, 1'b0, cetat_pkg::EscByte);
				default: configure(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					$urandom_range(0, 1) ? 8'd94 : 8'($urandom_range(1, 255)));
			endcase
			run_phase(PhaseItems, p % 3 == 1);
			drain();
		end
		if (board.errors == 0 && board.beats.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ===== color_escape_to_ansi_translator.f =====
sv/cetat_pkg.sv
sv/cetat_xlate.sv
sv/cetat_emit.sv
sv/color_escape_to_ansi_translator.sv
sim/color_escape_to_ansi_translator_test.sv
